FILE: rtl/cdoy_pkg.sv
// cdoy_pkg: shared types, constants and calendar table functions for the
// day-of-year converter. No dependencies; used by every cdoy_* module.
`default_nettype none

package cdoy_pkg;

	// command codes
	localparam logic CMD_TO_YEAR_DAY  = 1'b0;
	localparam logic CMD_TO_MONTH_DAY = 1'b1;

	// status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	// configuration register indexes and reset value
	localparam logic REG_EARLIEST_YEAR  = 1'b0;
	localparam logic [14:0] EARLIEST_YEAR_RST = 15'd1752;

	// reciprocal of 25 scaled by 2**20, exact quotient for 15-bit years
	localparam int RECIP_SHIFT = 20;
	localparam logic [15:0] RECIP_25 = 16'd41944;
	localparam int PROD_W = 31;

	// item between the leap stages and the conversion stages
	typedef struct packed {
		logic       command;
		logic       year_ok;
		logic       leap;
		logic [3:0] month;
		logic [4:0] day_of_month;
		logic [8:0] year_day;
	} cdoy_item_t;

	// length of month m (1..12), zero for a month number that means nothing
	function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		len = 5'd0;
		if (m == 4'd2) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else if (m inside {[4'd1:4'd12]}) begin
			len = 5'd31;
		end
		return len;
	endfunction

	// days in the months before month idx+1 (idx 0..11)
	function automatic logic [8:0] days_before(input logic leap, input logic [3:0] idx);
		logic [8:0] base;
		case (idx)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && idx >= 4'd2 && idx <= 4'd11) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cdoy_cfg.sv
// cdoy_cfg: APB-style register port holding earliest_year.
// Depends on cdoy_pkg.
`default_nettype none

module cdoy_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [14:0]      earliest_year
);

	logic [14:0] earliest_q;
	logic        hit;

	// word index is paddr[2]; only index zero exists
	assign hit    = (paddr[2] == cdoy_pkg::REG_EARLIEST_YEAR);
	assign pready = 1'b1;

	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earliest_q <= cdoy_pkg::EARLIEST_YEAR_RST;
		end else if (psel && penable && pwrite && hit) begin
			earliest_q <= pwdata[14:0];
		end
	end

	// read back
	always_comb begin
		prdata = 32'd0;
		if (hit) begin
			prdata = {17'd0, earliest_q};
		end
	end

	assign earliest_year = earliest_q;

endmodule

`default_nettype wire

FILE: rtl/cdoy_leap.sv
// cdoy_leap: first two pipeline stages; year range check and Gregorian
// leap rule via a reciprocal multiply by 1/25. Depends on cdoy_pkg.
`default_nettype none

module cdoy_leap (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic signed [15:0] year,
	input  wire logic [3:0]         month,
	input  wire logic [4:0]         day_of_month,
	input  wire logic [8:0]         year_day,
	input  wire logic [14:0]        earliest_year,
	input  wire logic               dn_ready,
	output logic                    dn_valid,
	output cdoy_pkg::cdoy_item_t    dn_item
);

	logic                    v_s1, v_s2;
	logic                    en_s1, en_s2;
	logic [cdoy_pkg::PROD_W-1:0] prod;

	logic        command_s1;
	logic        year_ok_s1;
	logic [14:0] year_s1;
	logic [10:0] quot_s1;
	logic [3:0]  month_s1;
	logic [4:0]  dom_s1;
	logic [8:0]  yd_s1;

	logic [14:0] q25;
	logic [14:0] rem25;
	logic        div25, div4, div16;

	cdoy_pkg::cdoy_item_t item_s2;

	// stage enables, a stage loads when empty or when it drains
	assign en_s2    = !v_s2 || dn_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// stage 1: quotient by 25 and year range check
	assign prod = {16'd0, year[14:0]} * {15'd0, cdoy_pkg::RECIP_25};

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			command_s1 <= command;
			year_ok_s1 <= !year[15] && (year[14:0] >= earliest_year);
			year_s1    <= year[14:0];
			quot_s1    <= prod[cdoy_pkg::RECIP_SHIFT +: 11];
			month_s1   <= month;
			dom_s1     <= day_of_month;
			yd_s1      <= year_day;
		end
	end

	// stage 2: remainder by 25, leap rule
	assign q25   = {quot_s1, 4'd0} + {1'b0, quot_s1, 3'd0} + {4'd0, quot_s1};
	assign rem25 = year_s1 - q25;
	assign div25 = (rem25 == 15'd0);
	assign div4  = (year_s1[1:0] == 2'd0);
	assign div16 = (year_s1[3:0] == 4'd0);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			item_s2.command      <= command_s1;
			item_s2.year_ok      <= year_ok_s1;
			item_s2.leap         <= div4 && (!div25 || div16);
			item_s2.month        <= month_s1;
			item_s2.day_of_month <= dom_s1;
			item_s2.year_day     <= yd_s1;
		end
	end

	assign dn_valid = v_s2;
	assign dn_item  = item_s2;

endmodule

`default_nettype wire

FILE: rtl/cdoy_conv.sv
// cdoy_conv: last two pipeline stages; month table lookup, range checks,
// month search and output register. Depends on cdoy_pkg.
`default_nettype none

module cdoy_conv (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            up_valid,
	output logic                 up_ready,
	input  wire cdoy_pkg::cdoy_item_t up_item,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 status,
	output logic [8:0]           result_year_day,
	output logic [3:0]           result_month,
	output logic [4:0]           result_day
);

	logic v_s3, v_s4;
	logic en_s3, en_s4;

	// stage 3 logic
	logic [4:0]  mlen;
	logic        ok_md;
	logic [8:0]  yd_sum;
	logic [8:0]  limit;
	logic        ok_yd;
	logic [10:0] past;
	logic [3:0]  month_idx;

	logic        command_s3;
	logic        ok_s3;
	logic        leap_s3;
	logic [8:0]  ryd_s3;
	logic [3:0]  midx_s3;
	logic [8:0]  yd_s3;

	logic [8:0]  rem_day;

	logic        status_s4;
	logic [8:0]  ryd_s4;
	logic [3:0]  rmon_s4;
	logic [4:0]  rday_s4;

	// stage enables
	assign en_s4    = !v_s4 || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign up_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= up_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// month/day to year-day checks and sum
	assign mlen   = cdoy_pkg::month_days(up_item.leap, up_item.month);
	assign ok_md  = (mlen != 5'd0) && (up_item.day_of_month != 5'd0) &&
	                (up_item.day_of_month <= mlen);
	assign yd_sum = cdoy_pkg::days_before(up_item.leap, up_item.month - 4'd1) +
	                9'(up_item.day_of_month);

	// year-day range and month search, one compare per month boundary
	assign limit = up_item.leap ? 9'd366 : 9'd365;
	assign ok_yd = (up_item.year_day != 9'd0) && (up_item.year_day <= limit);

	always_comb begin
		for (int i = 0; i < 11; i++) begin
			past[i] = up_item.year_day > cdoy_pkg::days_before(up_item.leap, 4'(i + 1));
		end
	end

	assign month_idx = 4'($countones(past));

	always_ff @(posedge clk) begin
		if (en_s3 && up_valid) begin
			command_s3 <= up_item.command;
			leap_s3    <= up_item.leap;
			ok_s3      <= up_item.year_ok &&
			              ((up_item.command == cdoy_pkg::CMD_TO_YEAR_DAY) ? ok_md : ok_yd);
			ryd_s3     <= yd_sum;
			midx_s3    <= month_idx;
			yd_s3      <= up_item.year_day;
		end
	end

	// stage 4: day within the found month, zero the unused fields
	assign rem_day = yd_s3 - cdoy_pkg::days_before(leap_s3, midx_s3);

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			status_s4 <= ok_s3 ? cdoy_pkg::STATUS_OK : cdoy_pkg::STATUS_INVALID;
			ryd_s4    <= (ok_s3 && command_s3 == cdoy_pkg::CMD_TO_YEAR_DAY) ?
			             ryd_s3 : 9'd0;
			rmon_s4   <= (ok_s3 && command_s3 == cdoy_pkg::CMD_TO_MONTH_DAY) ?
			             midx_s3 + 4'd1 : 4'd0;
			rday_s4   <= (ok_s3 && command_s3 == cdoy_pkg::CMD_TO_MONTH_DAY) ?
			             rem_day[4:0] : 5'd0;
		end
	end

	assign out_valid       = v_s4;
	assign status          = status_s4;
	assign result_year_day = ryd_s4;
	assign result_month    = rmon_s4;
	assign result_day      = rday_s4;

endmodule

`default_nettype wire

FILE: rtl/calendar_day_of_year_converter_unit.sv
// calendar_day_of_year_converter_unit: top level of the Gregorian
// day-of-year converter. Depends on cdoy_pkg, cdoy_cfg, cdoy_leap, cdoy_conv.
//
// Usage:
//   Input channel (in_valid/in_stall) carries command, year, month,
//   day_of_month and year_day. Command 0 gives the day of the year in
//   result_year_day; command 1 gives result_month and result_day.
//   Output channel (out_valid/out_stall) carries status and the results;
//   status 1 means the item was rejected and all results are zero.
//   A new item can be accepted every cycle while out_stall is low. The
//   four pipeline stages are year check with multiply by 1/25, leap
//   rule, table lookup with month search, and the output register.
//   When out_stall is high with a result waiting, the stages fill up and
//   in_stall rises once no empty stage is left; nothing is lost.
//   Reset clears all stage valid bits and sets earliest_year to 1752.
//   earliest_year lives at APB byte address 0; the user must write it
//   only while idle, as the block itself does not enforce this.
`default_nettype none

module calendar_day_of_year_converter_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic signed [15:0] year,
	input  wire logic [3:0]         month,
	input  wire logic [4:0]         day_of_month,
	input  wire logic [8:0]         year_day,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    status,
	output logic [8:0]              result_year_day,
	output logic [3:0]              result_month,
	output logic [4:0]              result_day
);

	logic [14:0]          earliest_year;
	logic                 mid_valid;
	logic                 mid_ready;
	cdoy_pkg::cdoy_item_t mid_item;

	// configuration register
	cdoy_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.earliest_year (earliest_year)
	);

	// year check and leap rule
	cdoy_leap u_leap (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.year          (year),
		.month         (month),
		.day_of_month  (day_of_month),
		.year_day      (year_day),
		.earliest_year (earliest_year),
		.dn_ready      (mid_ready),
		.dn_valid      (mid_valid),
		.dn_item       (mid_item)
	);

	// conversion and output register
	cdoy_conv u_conv (
		.clk             (clk),
		.arst_n          (arst_n),
		.up_valid        (mid_valid),
		.up_ready        (mid_ready),
		.up_item         (mid_item),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.result_year_day (result_year_day),
		.result_month    (result_month),
		.result_day      (result_day)
	);

endmodule

`default_nettype wire
